FILE: rtl/core/ats_pkg.sv
// shared types and constants for the animation timeline sequencer
// no dependencies; used by ats_div and animation_timeline_sequencer
`timescale 1ns / 1ps

package ats_pkg;

    // fixed field widths
    localparam int TIME_BITS   = 32;
    localparam int FRAC_BITS   = 16;
    localparam int REPEAT_BITS = 16;
    localparam int DUR_W       = 24;
    localparam int OFS_W       = 24;
    localparam int RC_W        = 17;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 3;

    // derived widths
    localparam int PROG_W     = FRAC_BITS + 2;
    localparam int QUOT_W     = FRAC_BITS + 1;
    localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);
    localparam int VX_W       = FRAC_BITS + 4;
    localparam int MAG_CMP_W  = (TIME_BITS > DUR_W + 1) ? TIME_BITS : DUR_W + 1;
    localparam int REP_CMP_W  = ((RC_W > REPEAT_BITS) ? RC_W : REPEAT_BITS) + 1;

    // progress constants in the extended working width
    localparam logic signed [VX_W-1:0] V_ONE = VX_W'(longint'(1) << FRAC_BITS);
    localparam logic signed [VX_W-1:0] V_MAX = VX_W'((longint'(1) << (FRAC_BITS + 1)) - 1);
    localparam logic signed [VX_W-1:0] V_MIN = VX_W'(-(longint'(1) << (FRAC_BITS + 1)));

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_START_NEXT = 2'd1,
        OP_START_NOW  = 2'd2,
        OP_CANCEL     = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DURATION     = 3'd0,
        CFG_START_OFFSET = 3'd1,
        CFG_REPEAT_COUNT = 3'd2,
        CFG_REPEAT_MODE  = 3'd3,
        CFG_FILL_ENABLED = 3'd4,
        CFG_FILL_BEFORE  = 3'd5,
        CFG_FILL_AFTER   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_opcode              opcode;
        logic [TIME_BITS-1:0] current_time;
    } t_in_item;

    typedef struct packed {
        logic signed [PROG_W-1:0] progress;
        logic                     applied;
        logic                     started_event;
        logic                     repeat_event;
        logic                     ended_event;
        logic                     more;
    } t_out_item;

    // divider request and response
    typedef struct packed {
        logic               start;
        logic [DUR_W:0]     mag;
        logic [DUR_W-1:0]   dur;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic              rem_nz;
    } t_div_rsp;

endpackage

FILE: rtl/core/animation_timeline_sequencer.sv
// animation timeline sequencer top level: control sequencer, state and config registers
// depends on ats_pkg and ats_div
`timescale 1ns / 1ps

// Takes one request at a time on the input channel: a tick or a start or cancel
// command, each with a millisecond time stamp, and returns exactly one result per
// request. A tick latches the start time if a start is pending, forms
// now - start - start_offset (modulo 2^32, read as signed) and divides it by the
// duration into signed Q2.16 progress, then applies the fill, clamp, reverse and
// repeat rules and raises the start, repeat and end events and the continue flag.
// The division runs on one serial restoring divider that produces one quotient bit
// per cycle, so a tick that needs it goes from acceptance to the next acceptance
// through latch and difference, magnitude, compare, 17 divider steps, the wait
// for the divider to finish, finish, result hand-off and idle. Ticks with zero
// duration or a saturated elapsed time skip the divider; a command goes from its
// state update straight to the hand-off. The hand-off waits while the output
// register still holds an unread result. The input is stalled while a request is
// in work; a finished result waits in an output register, so the next request is
// taken while it is unread.
// Configuration is written through a plain write port and should only change while
// the block is idle.

module animation_timeline_sequencer import ats_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_MAG,
        S_CMP,
        S_DIV,
        S_FIN,
        S_EMIT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [DUR_W-1:0]       r_duration;
    logic [OFS_W-1:0]       r_start_offset;
    logic signed [RC_W-1:0] r_repeat_count;
    logic                   r_repeat_mode;
    logic                   r_fill_enabled;
    logic                   r_fill_before;
    logic                   r_fill_after;

    // animation state
    logic [TIME_BITS-1:0]   r_start_stamp;
    logic                   r_start_pending;
    logic                   r_was_canceled;
    logic                   r_has_started;
    logic                   r_has_ended;
    logic                   r_dir_flipped;
    logic [REPEAT_BITS-1:0] r_repeats_done;
    logic                   r_extra_return;

    // request in work
    t_opcode                r_op;
    logic [TIME_BITS-1:0]   r_now;
    logic [TIME_BITS-1:0]   r_diff;
    logic [TIME_BITS-1:0]   r_mag;
    logic                   r_neg;
    logic                   r_below;
    logic                   r_above;
    logic                   r_atleast1;
    logic                   r_sat;
    t_out_item              r_res;

    // output register
    logic                   r_out_valid;
    t_out_item              r_out;

    // divider
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    ats_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    logic                   w_dur_zero;
    logic [TIME_BITS-1:0]   w_stamp_eff;
    logic [TIME_BITS-1:0]   w_diff;
    logic [MAG_CMP_W-1:0]   w_mag_x;
    logic [MAG_CMP_W-1:0]   w_dur_x;
    logic                   w_sat;
    logic                   w_out_free;
    t_out_item              w_cmd_res;

    assign w_dur_zero  = (r_duration == '0);
    // a pending start latches on this tick, so the stamp is the tick time itself
    assign w_stamp_eff = r_start_pending ? r_now : r_start_stamp;
    // offset only counts for a nonzero duration
    assign w_diff = r_now - w_stamp_eff
                  - (w_dur_zero ? TIME_BITS'(0) : TIME_BITS'(r_start_offset));

    assign w_mag_x = MAG_CMP_W'(r_mag);
    assign w_dur_x = MAG_CMP_W'(r_duration);
    assign w_sat   = (w_mag_x >= (w_dur_x << 1));

    assign w_out_free = !r_out_valid || !i_out_stall;

    // command result: all zero but the end event of a cancel that takes effect
    always_comb begin
        w_cmd_res             = '0;
        w_cmd_res.ended_event = (r_op == OP_CANCEL) && r_has_started && !r_has_ended;
    end

    // launch the divider from the compare step when a real quotient is needed
    always_comb begin
        w_div_req.start = (r_state == S_CMP) && !w_dur_zero && !w_sat;
        w_div_req.mag   = r_mag[DUR_W:0];
        w_div_req.dur   = r_duration;
    end

    // finish step: fill, clamp, flip and repeat rules
    logic signed [VX_W-1:0] n_v;
    logic signed [VX_W-1:0] w_q_ext;
    logic                   n_below;
    logic                   n_above;
    logic                   n_expired;
    logic                   n_keep;
    logic                   n_applied;
    logic                   n_st_ev;
    logic                   n_rp_ev;
    logic                   n_en_ev;
    logic                   n_more;
    logic                   n_has_started;
    logic                   n_has_ended;
    logic                   n_dir_flipped;
    logic [REPEAT_BITS-1:0] n_repeats_done;
    logic                   n_start_pending;
    logic                   n_extra_return;
    logic                   w_count_done;

    assign w_q_ext = VX_W'(w_div_rsp.quot);
    assign w_count_done = !r_repeat_count[RC_W-1]
        && (REP_CMP_W'(r_repeat_count[RC_W-2:0]) == REP_CMP_W'(r_repeats_done));

    always_comb begin
        n_below         = r_below;
        n_above         = r_above;
        n_applied       = 1'b0;
        n_st_ev         = 1'b0;
        n_rp_ev         = 1'b0;
        n_en_ev         = 1'b0;
        n_has_started   = r_has_started;
        n_has_ended     = r_has_ended;
        n_dir_flipped   = r_dir_flipped;
        n_repeats_done  = r_repeats_done;
        n_start_pending = r_start_pending;
        n_extra_return  = r_extra_return;

        // raw normalized time
        if (w_dur_zero) begin
            n_v = r_neg ? '0 : V_ONE;
        end else if (r_sat) begin
            n_v = r_neg ? V_MIN : V_MAX;
        end else if (r_neg) begin
            // before the start point the quotient rounds toward minus infinity
            n_v = -(w_q_ext + VX_W'(w_div_rsp.rem_nz));
        end else begin
            n_v = w_q_ext;
        end

        n_expired = r_atleast1 || r_was_canceled;
        n_keep    = !n_expired;

        // without fill, or with repeats, the window edges are forced
        if (!r_fill_enabled || (r_repeat_count != '0)) begin
            if (n_below) begin
                n_v     = '0;
                n_below = 1'b0;
            end
            if (n_above) begin
                n_v     = V_ONE;
                n_above = 1'b0;
            end
        end

        if ((!n_below || r_fill_before) && (!n_above || r_fill_after)) begin
            n_applied = 1'b1;
            if (!r_has_started) begin
                n_has_started = 1'b1;
                n_st_ev       = 1'b1;
            end
            if (r_fill_enabled) begin
                if (n_v < 0) begin
                    n_v = '0;
                end
                if (n_v > V_ONE) begin
                    n_v = V_ONE;
                end
            end
            if (r_dir_flipped) begin
                n_v = V_ONE - n_v;
                if (n_v > V_MAX) begin
                    n_v = V_MAX;
                end
                if (n_v < V_MIN) begin
                    n_v = V_MIN;
                end
            end
        end

        if (n_expired) begin
            if (w_count_done || r_was_canceled) begin
                if (!r_has_ended) begin
                    n_has_ended = 1'b1;
                    n_en_ev     = 1'b1;
                end
            end else begin
                if (!r_repeat_count[RC_W-1] && (r_repeat_count != '0)) begin
                    n_repeats_done = r_repeats_done + REPEAT_BITS'(1);
                end
                if (r_repeat_mode) begin
                    n_dir_flipped = !r_dir_flipped;
                end
                n_start_pending = 1'b1;
                n_keep          = 1'b1;
                n_rp_ev         = 1'b1;
            end
        end

        // one extra true return after the end
        if (!n_keep && r_extra_return) begin
            n_extra_return = 1'b0;
            n_more         = 1'b1;
        end else begin
            n_more = n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_duration      <= '0;
            r_start_offset  <= '0;
            r_repeat_count  <= '0;
            r_repeat_mode   <= 1'b0;
            r_fill_enabled  <= 1'b1;
            r_fill_before   <= 1'b0;
            r_fill_after    <= 1'b0;
            r_start_stamp   <= '0;
            r_start_pending <= 1'b1;
            r_was_canceled  <= 1'b0;
            r_has_started   <= 1'b0;
            r_has_ended     <= 1'b0;
            r_dir_flipped   <= 1'b0;
            r_repeats_done  <= '0;
            r_extra_return  <= 1'b1;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DURATION:     r_duration     <= i_cfg_data[DUR_W-1:0];
                    CFG_START_OFFSET: r_start_offset <= i_cfg_data[OFS_W-1:0];
                    CFG_REPEAT_COUNT: r_repeat_count <= i_cfg_data[RC_W-1:0];
                    CFG_REPEAT_MODE:  r_repeat_mode  <= i_cfg_data[0];
                    CFG_FILL_ENABLED: r_fill_enabled <= i_cfg_data[0];
                    CFG_FILL_BEFORE:  r_fill_before  <= i_cfg_data[0];
                    CFG_FILL_AFTER:   r_fill_after   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // result taken downstream; a hand-off on the same edge refills it below
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_data.opcode;
                        r_now   <= i_in_data.current_time;
                        r_state <= S_CALC;
                    end
                end

                S_CALC: begin
                    r_res <= w_cmd_res;
                    unique case (r_op)
                        OP_TICK: begin
                            if (r_start_pending) begin
                                r_start_stamp   <= r_now;
                                r_start_pending <= 1'b0;
                            end
                            r_diff  <= w_diff;
                            r_state <= S_MAG;
                        end
                        OP_START_NEXT, OP_START_NOW: begin
                            // restart keeps the extra return flag
                            r_start_pending <= (r_op == OP_START_NEXT);
                            if (r_op == OP_START_NOW) begin
                                r_start_stamp <= r_now;
                            end
                            r_was_canceled <= 1'b0;
                            r_has_started  <= 1'b0;
                            r_has_ended    <= 1'b0;
                            r_dir_flipped  <= 1'b0;
                            r_repeats_done <= '0;
                            r_state        <= S_EMIT;
                        end
                        OP_CANCEL: begin
                            // only a running animation can be canceled
                            if (r_has_started && !r_has_ended) begin
                                r_was_canceled  <= 1'b1;
                                r_start_pending <= 1'b0;
                                r_has_ended     <= 1'b1;
                            end
                            r_state <= S_EMIT;
                        end
                    endcase
                end

                S_MAG: begin
                    r_neg   <= r_diff[TIME_BITS-1];
                    r_mag   <= r_diff[TIME_BITS-1] ? (TIME_BITS'(0) - r_diff) : r_diff;
                    r_state <= S_CMP;
                end

                S_CMP: begin
                    // window flags use the exact elapsed time
                    if (w_dur_zero) begin
                        r_below    <= 1'b0;
                        r_above    <= 1'b0;
                        r_atleast1 <= !r_neg;
                    end else begin
                        r_below    <= r_neg;
                        r_above    <= !r_neg && (w_mag_x > w_dur_x);
                        r_atleast1 <= !r_neg && (w_mag_x >= w_dur_x);
                    end
                    r_sat   <= w_sat;
                    r_state <= w_div_req.start ? S_DIV : S_FIN;
                end

                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_FIN;
                    end
                end

                S_FIN: begin
                    r_has_started         <= n_has_started;
                    r_has_ended           <= n_has_ended;
                    r_dir_flipped         <= n_dir_flipped;
                    r_repeats_done        <= n_repeats_done;
                    r_start_pending       <= n_start_pending;
                    r_extra_return        <= n_extra_return;
                    r_res.progress        <= n_v[PROG_W-1:0];
                    r_res.applied         <= n_applied;
                    r_res.started_event   <= n_st_ev;
                    r_res.repeat_event    <= n_rp_ev;
                    r_res.ended_event     <= n_en_ev;
                    r_res.more            <= n_more;
                    r_state               <= S_EMIT;
                end

                S_EMIT: begin
                    // hand the result over once the output register is free
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/ats_div.sv
// serial restoring divider: (mag << FRAC_BITS) / dur, one quotient bit per cycle
// depends on ats_pkg
`timescale 1ns / 1ps

module ats_div import ats_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DUR_W-1:0]     r_rem;
    logic [DUR_W-1:0]     r_dur;
    logic [QUOT_W-1:0]    r_sh;
    logic [QUOT_W-1:0]    r_quot;

    logic [DUR_W:0]   w_trial;
    logic [DUR_W+1:0] w_sub;
    logic             w_ge;

    // partial remainder stays below dur, so the trial fits one extra bit
    assign w_trial = {r_rem, r_sh[QUOT_W-1]};
    assign w_sub   = (DUR_W+2)'(w_trial) - (DUR_W+2)'(r_dur);
    assign w_ge    = !w_sub[DUR_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(QUOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.mag[DUR_W:1];
            r_sh  <= {i_req.mag[0], (QUOT_W-1)'(0)};
            r_dur <= i_req.dur;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_sub[DUR_W-1:0];
            end else begin
                r_rem <= w_trial[DUR_W-1:0];
            end
            r_sh   <= {r_sh[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quot   = r_quot;
    assign o_rsp.rem_nz = |r_rem;

endmodule
